// ===== rtl/core/wsd_pkg.sv =====
// Package for the frame deframer: word types, parser phases and queue constants.
package wsd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       truncated;
    } out_word_t;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT     = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [6:0] LenCode16 = 7'd126;
    localparam logic [6:0] LenCode64 = 7'd127;
    localparam logic [3:0] ExtBytes16 = 4'd2;
    localparam logic [3:0] ExtBytes64 = 4'd8;
    localparam logic [3:0] KeyBytes   = 4'd4;

endpackage

// ===== rtl/core/wsd_parser.sv =====
// Front end: header parser, length counter and payload unmasking.
module wsd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              data_valid,
    output logic              data_ready,
    input  wsd_pkg::in_word_t data,
    input  logic              q_full,
    output logic              push,
    output wsd_pkg::out_word_t push_word
);
    import wsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic [63:0] remaining_reg, remaining_next;
    logic        mask_reg, mask_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  kidx_reg, kidx_next;
    logic        ext_long_reg, ext_long_next;

    logic        accept;
    logic        emit;
    logic [7:0]  kbyte;
    logic [3:0]  hcount_inc;
    logic [3:0]  ext_bytes;
    logic        hdr_zero;

    assign data_ready = !q_full;
    assign accept     = data_valid && data_ready;
    assign hcount_inc = hcount_reg + 4'd1;
    assign ext_bytes  = ext_long_reg ? ExtBytes64 : ExtBytes16;

    always_comb
    begin
        phase_next     = phase_reg;
        hcount_next    = hcount_reg;
        remaining_next = remaining_reg;
        mask_next      = mask_reg;
        key_next       = key_reg;
        kidx_next      = kidx_reg;
        ext_long_next  = ext_long_reg;
        emit           = 1'b0;
        push_word      = '0;
        kbyte          = '0;
        hdr_zero       = 1'b0;

        unique case (phase_reg)
            PH_FIRST:
            begin
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                mask_next      = data.data_byte[7];
                hcount_next    = '0;
                remaining_next = '0;
                if (data.data_byte[6:0] == LenCode16)
                begin
                    ext_long_next = 1'b0;
                    phase_next    = PH_EXT;
                end
                else if (data.data_byte[6:0] == LenCode64)
                begin
                    ext_long_next = 1'b1;
                    phase_next    = PH_EXT;
                end
                else
                begin
                    remaining_next = {57'd0, data.data_byte[6:0]};
                    if (data.data_byte[7])
                        phase_next = PH_KEY;
                    else if (data.data_byte[6:0] == 7'd0)
                        hdr_zero = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_EXT:
            begin
                remaining_next = {remaining_reg[55:0], data.data_byte};
                hcount_next    = hcount_inc;
                if (hcount_inc >= ext_bytes)
                begin
                    hcount_next = '0;
                    if (mask_reg)
                        phase_next = PH_KEY;
                    else if (remaining_next == 64'd0)
                        hdr_zero = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_KEY:
            begin
                key_next    = {key_reg[23:0], data.data_byte};
                hcount_next = hcount_inc;
                if (hcount_inc >= KeyBytes)
                begin
                    hcount_next = '0;
                    if (remaining_reg == 64'd0)
                        hdr_zero = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (mask_reg)
                begin
                    case (kidx_reg)
                        2'd0:    kbyte = key_reg[31:24];
                        2'd1:    kbyte = key_reg[23:16];
                        2'd2:    kbyte = key_reg[15:8];
                        default: kbyte = key_reg[7:0];
                    endcase
                end
                push_word.payload_byte = data.data_byte ^ kbyte;
                push_word.byte_valid   = 1'b1;
                emit                   = 1'b1;
                kidx_next              = kidx_reg + 2'd1;
                remaining_next         = remaining_reg - 64'd1;
                if (remaining_reg == 64'd1)
                begin
                    push_word.frame_end = 1'b1;
                    phase_next          = PH_DONE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (hdr_zero)
        begin
            phase_next          = PH_DONE;
            emit                = 1'b1;
            push_word.frame_end = 1'b1;
        end

        if (data.buffer_end)
        begin
            if (phase_next != PH_DONE)
            begin
                emit                = 1'b1;
                push_word.truncated = 1'b1;
            end
            phase_next     = PH_FIRST;
            hcount_next    = '0;
            remaining_next = '0;
            mask_next      = 1'b0;
            key_next       = '0;
            kidx_next      = '0;
            ext_long_next  = 1'b0;
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            hcount_reg    <= '0;
            remaining_reg <= '0;
            mask_reg      <= 1'b0;
            key_reg       <= '0;
            kidx_reg      <= '0;
            ext_long_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            hcount_reg    <= hcount_next;
            remaining_reg <= remaining_next;
            mask_reg      <= mask_next;
            key_reg       <= key_next;
            kidx_reg      <= kidx_next;
            ext_long_reg  <= ext_long_next;
        end
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && data.buffer_end) |=> (phase_reg == PH_FIRST && remaining_reg == 64'd0))
        else $error("parser did not restart after buffer end");

    a_trunc_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_word.truncated) |-> data.buffer_end)
        else $error("truncated word without buffer end");

    a_payload_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remaining_reg != 64'd0))
        else $error("payload phase with zero remaining length");

endmodule

// ===== rtl/core/wsd_queue.sv =====
// Short result queue between the parser and the output stage.
module wsd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  wsd_pkg::out_word_t push_word,
    output logic               full,
    output logic               not_empty,
    input  logic               pop,
    output wsd_pkg::out_word_t head_word
);
    import wsd_pkg::*;

    out_word_t              mem [QDepth];
    logic [QPtrW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0]       count_reg, count_next;

    assign full      = (count_reg == QCntW'(QDepth));
    assign not_empty = (count_reg != '0);
    assign head_word = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/wsd_out_stage.sv =====
// Back end: registered output stage driving the result channel.
module wsd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  wsd_pkg::out_word_t head_word,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output wsd_pkg::out_word_t result
);
    import wsd_pkg::*;

    logic      valid_reg;
    out_word_t word_reg;

    assign pop          = q_not_empty && (!valid_reg || result_ready);
    assign result_valid = valid_reg;
    assign result       = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || result_ready)
            valid_reg <= q_not_empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            word_reg <= head_word;
    end

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// Top level of the frame deframer: parser, result queue and output stage.
// Input channel (data_valid/data_ready/data): one buffer byte per word, with
// buffer_end set on the last byte of a received buffer. The first header byte
// is skipped, the length, extended length and mask key are parsed, and each
// payload byte leaves unmasked on the result channel
// (result_valid/result_ready/result). frame_end marks the last payload byte
// or an empty frame; truncated marks a buffer that ended before its frame.
// Otherwise header bytes and bytes after the frame give no result word.
// Throughput: one byte per cycle while the queue has room; the parser updates
// its state on every accepted byte, including the 64-bit length decrement.
// Each result word is written into the queue when its byte is accepted and
// is then loaded into the output register once that register is free.
// A stalled receiver fills the 4-word queue; data_ready then drops until a
// word is taken. Header bytes are still taken only while the queue has room.
// Reset clears the parser to the first header byte and empties the queue and
// the output register. After every buffer end the parser starts over.
module websocket_frame_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               data_valid,
    output logic               data_ready,
    input  wsd_pkg::in_word_t  data,
    output logic               result_valid,
    input  logic               result_ready,
    output wsd_pkg::out_word_t result
);
    import wsd_pkg::*;

    logic      push;
    out_word_t push_word;
    logic      q_full;
    logic      q_not_empty;
    logic      pop;
    out_word_t head_word;

    wsd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data       (data),
        .q_full     (q_full),
        .push       (push),
        .push_word  (push_word)
    );

    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .pop        (pop),
        .head_word  (head_word)
    );

    wsd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .head_word    (head_word),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
